FILE: design/jops_pkg.sv
// shared constants, types and helpers of the json object partition splitter
package jops_pkg;

  localparam int OFFSET_BITS    = 40;
  localparam int MAX_PARTITIONS = 64;
  localparam int DEPTH_BITS     = 16;
  localparam int PC_BITS        = 7;
  localparam int NP_BITS        = $clog2(MAX_PARTITIONS + 1);
  localparam int REM_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CFG_IDX_BITS   = 2;
  localparam int DIV_CNT_BITS   = $clog2(OFFSET_BITS + 1);

  typedef logic [OFFSET_BITS-1:0] ofs_t;
  typedef logic [DEPTH_BITS-1:0]  depth_t;
  typedef logic [NP_BITS-1:0]     np_t;
  typedef logic [REM_BITS-1:0]    rem_t;
  typedef logic [1:0]             stat_t;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;

  localparam depth_t DEPTH_MAX = '1;

  localparam stat_t STAT_PART      = 2'd0;
  localparam stat_t STAT_FINAL     = 2'd1;
  localparam stat_t STAT_MALFORMED = 2'd2;
  localparam stat_t STAT_NO_EVENTS = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ARRAY_START = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAYLOAD_LEN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PART_COUNT  = 2'd2;

  typedef struct packed {
    ofs_t  range_start;
    ofs_t  range_stop;
    stat_t status;
    logic  last_result;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_qr;
    logic prep_step;
    logic adv_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fifo_ok;
    logic adv_req;
    logic div_done;
    logic prep_done;
    logic adv_more;
  } sts_t;

  // zero counts as one, large counts saturate
  function automatic np_t eff_count(input logic [PC_BITS-1:0] pc);
    int unsigned v;
    v = 32'(pc);
    if (v == 0) begin
      v = 1;
    end else if (v > MAX_PARTITIONS) begin
      v = MAX_PARTITIONS;
    end
    return NP_BITS'(v);
  endfunction

endpackage

FILE: design/jops_in_if.sv
// byte input channel
interface jops_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

FILE: design/jops_out_if.sv
// range result channel
interface jops_out_if;
  logic                            valid;
  logic                            ready;
  logic [jops_pkg::OFFSET_BITS-1:0] range_start;
  logic [jops_pkg::OFFSET_BITS-1:0] range_stop;
  logic [1:0]                      status;
  logic                            last_result;
  modport source (output valid, output range_start, output range_stop, output status,
                  output last_result, input ready);
  modport sink (input valid, input range_start, input range_stop, input status,
                input last_result, output ready);
endinterface

FILE: design/jops_cfg_if.sv
// configuration write channel
interface jops_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [jops_pkg::CFG_IDX_BITS-1:0] index;
  logic [jops_pkg::OFFSET_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/json_object_partition_splitter_top.sv
// top level of the json object partition splitter
// Scans a json array body one byte per transaction and cuts the top-level objects into byte
// ranges near balanced targets. A byte is taken every cycle in steady flow, when no cut, no
// register write and no untaken result holds the input. A cut on a byte that does not end
// the buffer holds the input while the target sequence is stepped past every further target
// the cut object has passed, one index per cycle by a single adder. After reset and after any
// register write the input is held while a bit-serial divider forms payload_length / count,
// then the target is stepped from the array start up to the index of the pending partition.
// A byte that both cuts a partition and ends the buffer gives two results; the next byte waits
// until the two-entry result buffer has drained. The configuration port is always ready.
module json_object_partition_splitter_top (
  input logic        clk,
  input logic        rst_n,
  jops_in_if.sink    in_ch,
  jops_out_if.source out_ch,
  jops_cfg_if.sink   cfg_ch
);
  import jops_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  jops_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cfg_fire (cfg_fire),
    .cmd      (cmd),
    .sts      (sts)
  );

  jops_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .cfg_fire   (cfg_fire),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_ch     (out_ch)
  );

endmodule

FILE: design/jops_div.sv
// iterative restoring divider, one quotient bit per cycle
module jops_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [jops_pkg::OFFSET_BITS-1:0] dividend,
  input  logic [jops_pkg::NP_BITS-1:0]     divisor,
  output logic                        done,
  output logic [jops_pkg::OFFSET_BITS-1:0] quot,
  output logic [jops_pkg::REM_BITS-1:0]    rem
);
  import jops_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  ofs_t                    work_r, work_nxt;
  np_t                     rem_r, rem_nxt;
  np_t                     div_r, div_nxt;
  logic [NP_BITS:0]        rem_s;
  logic                    ge;

  assign rem_s = {rem_r, work_r[OFFSET_BITS-1]};
  assign ge    = rem_s >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(OFFSET_BITS);
      work_nxt = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[OFFSET_BITS-2:0], ge};
      rem_nxt  = ge ? NP_BITS'(rem_s - {1'b0, div_r}) : rem_s[NP_BITS-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done = done_r;
  assign quot = work_r;
  assign rem  = REM_BITS'(rem_r);

endmodule

FILE: design/jops_datapath.sv
// scan state, partition targets, configuration registers and result buffer
module jops_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jops_pkg::cmd_t                    cmd,
  output jops_pkg::sts_t                    sts,
  input  logic [7:0]                        data_byte,
  input  logic                              final_byte,
  input  logic                              cfg_fire,
  input  logic [jops_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [jops_pkg::OFFSET_BITS-1:0]  cfg_data,
  jops_out_if.source                        out_ch
);
  import jops_pkg::*;

  // configuration
  ofs_t                 array_start_r, array_start_nxt;
  ofs_t                 payload_len_r, payload_len_nxt;
  logic [PC_BITS-1:0]   part_count_r, part_count_nxt;
  // scan state
  ofs_t   bytepos_r, bytepos_nxt;
  logic   in_obj_r, in_obj_nxt;
  depth_t depth_r, depth_nxt;
  logic   in_str_r, in_str_nxt;
  logic   esc_r, esc_nxt;
  ofs_t   obj_start_r, obj_start_nxt;
  ofs_t   pstart_r, pstart_nxt;
  np_t    np_r, np_nxt;
  ofs_t   last_end_r, last_end_nxt;
  logic   closed_r, closed_nxt;
  logic   ovf_r, ovf_nxt;
  logic   fresh_r, fresh_nxt;
  // target generator
  ofs_t   q_r, q_nxt;
  rem_t   r_r, r_nxt;
  ofs_t   tgt_r, tgt_nxt;
  rem_t   g_r, g_nxt;
  np_t    prep_idx_r, prep_idx_nxt;
  // result buffer
  result_t    slot_r [2];
  result_t    slot_nxt [2];
  logic [1:0] count_r, count_nxt;

  np_t            eff_cnt;
  logic [REM_BITS:0] g_sum;
  logic           g_wrap;
  ofs_t           step_tgt;
  rem_t           step_g;
  ofs_t           div_q;
  rem_t           div_rem;
  logic           div_done;
  logic           pop;

  logic   s_in_obj, s_in_str, s_esc, s_closed, s_ovf, s_done;
  depth_t s_depth, d_dec;
  ofs_t   s_obj_start, s_last_end, s_pstart;
  logic   emit;
  result_t res_emit, res_close;

  assign eff_cnt = eff_count(part_count_r);

  jops_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (payload_len_r),
    .divisor  (eff_cnt),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // target(i+1) = target(i) + q + carry of the r*i/count fraction
  assign g_sum    = {1'b0, g_r} + {1'b0, r_r};
  assign g_wrap   = g_sum >= (REM_BITS + 1)'(eff_cnt);
  assign step_tgt = tgt_r + q_r + OFFSET_BITS'(g_wrap);
  assign step_g   = g_wrap ? REM_BITS'(g_sum - (REM_BITS + 1)'(eff_cnt)) : g_sum[REM_BITS-1:0];

  // bracket, string and escape tracking for the offered byte
  always_comb begin
    s_in_obj    = in_obj_r;
    s_depth     = depth_r;
    s_in_str    = in_str_r;
    s_esc       = esc_r;
    s_obj_start = obj_start_r;
    s_closed    = closed_r;
    s_ovf       = ovf_r;
    s_done      = 1'b0;
    d_dec       = (depth_r != '0) ? depth_r - 1'b1 : depth_r;
    if (!closed_r) begin
      if (!in_obj_r) begin
        if (data_byte == CH_LBRACE) begin
          s_in_obj    = 1'b1;
          s_depth     = DEPTH_BITS'(1);
          s_in_str    = 1'b0;
          s_esc       = 1'b0;
          s_obj_start = bytepos_r;
        end else if (data_byte == CH_RBRACKET) begin
          s_closed = 1'b1;
        end
      end else if (in_str_r) begin
        if (esc_r) begin
          s_esc = 1'b0;
        end else if (data_byte == CH_BSLASH) begin
          s_esc = 1'b1;
        end else if (data_byte == CH_QUOTE) begin
          s_in_str = 1'b0;
        end
      end else if (data_byte == CH_QUOTE) begin
        s_in_str = 1'b1;
      end else if (data_byte == CH_LBRACE) begin
        if (depth_r == DEPTH_MAX) begin
          s_ovf = 1'b1;
        end else begin
          s_depth = depth_r + 1'b1;
        end
      end else if (data_byte == CH_RBRACE) begin
        s_depth = d_dec;
        if (d_dec == '0) begin
          s_done   = 1'b1;
          s_in_obj = 1'b0;
        end
      end
    end
  end

  assign emit = s_done && (eff_cnt > NP_BITS'(1)) && (np_r < eff_cnt) &&
                (obj_start_r >= tgt_r) && (obj_start_r > pstart_r);
  assign s_last_end = s_done ? bytepos_r + 1'b1 : last_end_r;
  assign s_pstart   = emit ? obj_start_r : pstart_r;

  always_comb begin
    res_emit.range_start = pstart_r;
    res_emit.range_stop  = obj_start_r;
    res_emit.status      = STAT_PART;
    res_emit.last_result = 1'b0;

    res_close.range_start = '0;
    res_close.range_stop  = '0;
    res_close.last_result = 1'b1;
    if (eff_cnt <= NP_BITS'(1)) begin
      res_close.range_start = array_start_r;
      res_close.range_stop  = array_start_r + payload_len_r;
      res_close.status      = STAT_FINAL;
    end else if (s_in_obj || s_ovf) begin
      res_close.status = STAT_MALFORMED;
    end else if (s_last_end == array_start_r) begin
      res_close.status = STAT_NO_EVENTS;
    end else begin
      res_close.range_start = s_pstart;
      res_close.range_stop  = s_last_end;
      res_close.status      = STAT_FINAL;
    end
  end

  assign pop = (count_r != 2'd0) && out_ch.ready;

  always_comb begin
    array_start_nxt = array_start_r;
    payload_len_nxt = payload_len_r;
    part_count_nxt  = part_count_r;
    bytepos_nxt     = bytepos_r;
    in_obj_nxt      = in_obj_r;
    depth_nxt       = depth_r;
    in_str_nxt      = in_str_r;
    esc_nxt         = esc_r;
    obj_start_nxt   = obj_start_r;
    pstart_nxt      = pstart_r;
    np_nxt          = np_r;
    last_end_nxt    = last_end_r;
    closed_nxt      = closed_r;
    ovf_nxt         = ovf_r;
    fresh_nxt       = fresh_r;
    q_nxt           = q_r;
    r_nxt           = r_r;
    tgt_nxt         = tgt_r;
    g_nxt           = g_r;
    prep_idx_nxt    = prep_idx_r;
    slot_nxt[0]     = slot_r[0];
    slot_nxt[1]     = slot_r[1];
    count_nxt       = count_r;

    if (pop) begin
      slot_nxt[0] = slot_r[1];
      count_nxt   = count_r - 1'b1;
    end

    if (cmd.accept) begin
      if (final_byte) begin
        bytepos_nxt   = array_start_r;
        in_obj_nxt    = 1'b0;
        depth_nxt     = '0;
        in_str_nxt    = 1'b0;
        esc_nxt       = 1'b0;
        obj_start_nxt = '0;
        pstart_nxt    = array_start_r;
        np_nxt        = NP_BITS'(1);
        last_end_nxt  = array_start_r;
        closed_nxt    = 1'b0;
        ovf_nxt       = 1'b0;
        fresh_nxt     = 1'b1;
        // target of partition one, fraction r*1/count is below one
        tgt_nxt       = array_start_r + q_r;
        g_nxt         = r_r;
        if (emit) begin
          slot_nxt[0] = res_emit;
          slot_nxt[1] = res_close;
          count_nxt   = 2'd2;
        end else begin
          slot_nxt[0] = res_close;
          count_nxt   = 2'd1;
        end
      end else begin
        bytepos_nxt   = bytepos_r + 1'b1;
        in_obj_nxt    = s_in_obj;
        depth_nxt     = s_depth;
        in_str_nxt    = s_in_str;
        esc_nxt       = s_esc;
        obj_start_nxt = s_obj_start;
        pstart_nxt    = s_pstart;
        last_end_nxt  = s_last_end;
        closed_nxt    = s_closed;
        ovf_nxt       = s_ovf;
        fresh_nxt     = 1'b0;
        if (emit) begin
          np_nxt      = np_r + 1'b1;
          tgt_nxt     = step_tgt;
          g_nxt       = step_g;
          slot_nxt[0] = res_emit;
          count_nxt   = 2'd1;
        end
      end
    end

    if (cmd.adv_step) begin
      np_nxt  = np_r + 1'b1;
      tgt_nxt = step_tgt;
      g_nxt   = step_g;
    end

    if (cmd.prep_step) begin
      prep_idx_nxt = prep_idx_r + 1'b1;
      tgt_nxt      = step_tgt;
      g_nxt        = step_g;
    end

    if (cmd.load_qr) begin
      q_nxt        = div_q;
      r_nxt        = div_rem;
      tgt_nxt      = array_start_r;
      g_nxt        = '0;
      prep_idx_nxt = '0;
    end

    if (cfg_fire) begin
      case (cfg_index)
        REG_ARRAY_START: begin
          array_start_nxt = cfg_data;
          if (fresh_r) begin
            bytepos_nxt  = cfg_data;
            pstart_nxt   = cfg_data;
            last_end_nxt = cfg_data;
          end
        end
        REG_PAYLOAD_LEN: payload_len_nxt = cfg_data;
        REG_PART_COUNT:  part_count_nxt  = cfg_data[PC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_start_r <= '0;
      payload_len_r <= '0;
      part_count_r  <= PC_BITS'(1);
      bytepos_r     <= '0;
      in_obj_r      <= 1'b0;
      depth_r       <= '0;
      in_str_r      <= 1'b0;
      esc_r         <= 1'b0;
      pstart_r      <= '0;
      np_r          <= NP_BITS'(1);
      last_end_r    <= '0;
      closed_r      <= 1'b0;
      ovf_r         <= 1'b0;
      fresh_r       <= 1'b1;
      count_r       <= 2'd0;
    end else begin
      array_start_r <= array_start_nxt;
      payload_len_r <= payload_len_nxt;
      part_count_r  <= part_count_nxt;
      bytepos_r     <= bytepos_nxt;
      in_obj_r      <= in_obj_nxt;
      depth_r       <= depth_nxt;
      in_str_r      <= in_str_nxt;
      esc_r         <= esc_nxt;
      pstart_r      <= pstart_nxt;
      np_r          <= np_nxt;
      last_end_r    <= last_end_nxt;
      closed_r      <= closed_nxt;
      ovf_r         <= ovf_nxt;
      fresh_r       <= fresh_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obj_start_r <= obj_start_nxt;
    q_r         <= q_nxt;
    r_r         <= r_nxt;
    tgt_r       <= tgt_nxt;
    g_r         <= g_nxt;
    prep_idx_r  <= prep_idx_nxt;
    slot_r[0]   <= slot_nxt[0];
    slot_r[1]   <= slot_nxt[1];
  end

  assign sts.fifo_ok   = (count_r == 2'd0) || ((count_r == 2'd1) && pop);
  assign sts.adv_req   = emit && !final_byte;
  assign sts.div_done  = div_done;
  assign sts.prep_done = prep_idx_r == np_r;
  assign sts.adv_more  = (np_r < eff_cnt) && (obj_start_r >= tgt_r);

  assign out_ch.valid       = count_r != 2'd0;
  assign out_ch.range_start = slot_r[0].range_start;
  assign out_ch.range_stop  = slot_r[0].range_stop;
  assign out_ch.status      = slot_r[0].status;
  assign out_ch.last_result = slot_r[0].last_result;

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer holds more than two entries");

  a_full_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> !cmd.accept)
    else $error("byte taken while result buffer is full");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && final_byte) |=> (np_r == NP_BITS'(1)) && fresh_r && !in_obj_r)
    else $error("scan state not cleared after closing byte");

endmodule

FILE: design/jops_ctrl.sv
// sequencer: target setup after configuration, byte intake and target advance
module jops_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           cfg_fire,
  output jops_pkg::cmd_t cmd,
  input  jops_pkg::sts_t sts
);
  import jops_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_PSTEP = 2'd2;
  localparam logic [1:0] ST_ADV   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       dirty_r, dirty_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (dirty_r) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          in_ready   = sts.fifo_ok;
          cmd.accept = in_valid && sts.fifo_ok;
          if (cmd.accept && sts.adv_req) begin
            state_nxt = ST_ADV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.load_qr = 1'b1;
          state_nxt   = ST_PSTEP;
        end
      end
      // walk the target up to the current partition index
      ST_PSTEP: begin
        if (sts.prep_done) begin
          state_nxt = ST_RUN;
        end else begin
          cmd.prep_step = 1'b1;
        end
      end
      // skip every target the cut object already passed
      ST_ADV: begin
        if (sts.adv_more) begin
          cmd.adv_step = 1'b1;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // a register write invalidates quotient, remainder and target
  assign dirty_nxt = (dirty_r && !cmd.div_start) || cfg_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !cmd.accept)
    else $error("byte taken before targets were rebuilt");

  a_cut_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.adv_req) |=> (state_r == ST_ADV) && !in_ready)
    else $error("partition cut did not hold input for target advance");

endmodule

FILE: dv/json_object_partition_splitter_top_test.sv
// testbench of the json object partition splitter: json byte streams checked against a scan model
`timescale 1ns / 100ps
module json_object_partition_splitter_top_test;
  import jops_pkg::*;

  localparam int IDLE_PCT      = 28;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 120;
  localparam int DRAIN_CYCLES  = 120;
  localparam int RANDOM_BYTES  = 1400;
  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } feed_t;

  logic clk;
  logic rst_n;

  jops_in_if  in_ch ();
  jops_out_if out_ch ();
  jops_cfg_if cfg_ch ();

  json_object_partition_splitter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  feed_t       feed_q[$];
  logic [7:0]  stage_q[$];
  result_t     expected_ranges[$];
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned err_count;
  int unsigned quiet_cycles;
  bit          calm;
  string       filler_chars = "ab:01 ,.n[tz";
  string       gap_chars = " ,\n\t";

  // scan model: registers
  ofs_t               base_ofs;
  ofs_t               pay_len;
  logic [PC_BITS-1:0] req_count;
  // scan model: per-buffer state
  ofs_t        scan_pos;
  ofs_t        obj_start;
  ofs_t        cut_start;
  ofs_t        last_end;
  depth_t      depth;
  int unsigned cut_idx;
  bit          in_obj;
  bit          in_str;
  bit          esc;
  bit          closed;
  bit          overflow;
  bit          fresh_buf;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned live_count();
    if (req_count == 0) return 1;
    if (req_count > MAX_PARTITIONS) return MAX_PARTITIONS;
    return 32'(req_count);
  endfunction

  function automatic ofs_t cut_target(input int unsigned idx, input int unsigned cnt);
    longint unsigned q;
    longint unsigned r;
    q = 64'(pay_len) / cnt;
    r = 64'(pay_len) % cnt;
    return ofs_t'(64'(base_ofs) + q * idx + (r * idx) / cnt);
  endfunction

  task automatic restart_scan();
    scan_pos  = base_ofs;
    in_obj    = 1'b0;
    depth     = '0;
    in_str    = 1'b0;
    esc       = 1'b0;
    obj_start = '0;
    cut_start = base_ofs;
    cut_idx   = 1;
    last_end  = base_ofs;
    closed    = 1'b0;
    overflow  = 1'b0;
    fresh_buf = 1'b1;
  endtask

  task automatic push_range(input ofs_t a, input ofs_t b, input stat_t st, input logic last);
    result_t r;
    r.range_start = a;
    r.range_stop  = b;
    r.status      = st;
    r.last_result = last;
    expected_ranges.insert(expected_ranges.size(), r);
  endtask

  task automatic close_object(input ofs_t pos);
    int unsigned cnt;
    cnt = live_count();
    in_obj = 1'b0;
    last_end = pos + 1'b1;
    if (cnt > 1 && cut_idx < cnt && obj_start >= cut_target(cut_idx, cnt) &&
        obj_start > cut_start) begin
      push_range(cut_start, obj_start, STAT_PART, 1'b0);
      cut_start = obj_start;
      // skip every target the object start has already passed
      do begin
        cut_idx++;
      end while (cut_idx < cnt && obj_start >= cut_target(cut_idx, cnt));
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic fin);
    ofs_t pos;
    pos = scan_pos;
    fresh_buf = 1'b0;
    if (!closed) begin
      if (!in_obj) begin
        if (b == CH_LBRACE) begin
          in_obj = 1'b1;
          depth = depth_t'(1);
          in_str = 1'b0;
          esc = 1'b0;
          obj_start = pos;
        end else if (b == CH_RBRACKET) begin
          closed = 1'b1;
        end
      end else if (in_str) begin
        if (esc) esc = 1'b0;
        else if (b == CH_BSLASH) esc = 1'b1;
        else if (b == CH_QUOTE) in_str = 1'b0;
      end else if (b == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (b == CH_LBRACE) begin
        if (depth == DEPTH_MAX) overflow = 1'b1;
        else depth++;
      end else if (b == CH_RBRACE) begin
        if (depth != 0) depth--;
        if (depth == 0) close_object(pos);
      end
    end
    scan_pos = pos + 1'b1;
    if (fin) begin
      if (live_count() <= 1) push_range(base_ofs, base_ofs + pay_len, STAT_FINAL, 1'b1);
      else if (in_obj || overflow) push_range('0, '0, STAT_MALFORMED, 1'b1);
      else if (last_end == base_ofs) push_range('0, '0, STAT_NO_EVENTS, 1'b1);
      else push_range(cut_start, last_end, STAT_FINAL, 1'b1);
      restart_scan();
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx, input ofs_t val);
    case (idx)
      REG_ARRAY_START: begin
        base_ofs = val;
        if (fresh_buf) begin
          scan_pos = base_ofs;
          cut_start = base_ofs;
          last_end = base_ofs;
        end
      end
      REG_PAYLOAD_LEN: pay_len = val;
      REG_PART_COUNT:  req_count = val[PC_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_range();
    result_t want;
    if (expected_ranges.size() == 0) begin
      report_mismatch($sformatf("unexpected result start %0h stop %0h status %0d last %0b",
                                out_ch.range_start, out_ch.range_stop, out_ch.status,
                                out_ch.last_result));
      return;
    end
    want = expected_ranges.pop_front();
    if (out_ch.range_start !== want.range_start)
      report_mismatch($sformatf("range_start got %0h want %0h", out_ch.range_start,
                                want.range_start));
    if (out_ch.range_stop !== want.range_stop)
      report_mismatch($sformatf("range_stop got %0h want %0h", out_ch.range_stop,
                                want.range_stop));
    if (out_ch.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
    if (out_ch.last_result !== want.last_result)
      report_mismatch($sformatf("last_result got %0b want %0b", out_ch.last_result,
                                want.last_result));
  endtask

  // byte driver, the model steps on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.data_byte, in_ch.final_byte);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= feed_q[0].data;
          in_ch.final_byte <= feed_q[0].fin;
          void'(feed_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_range();
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input ofs_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for all bytes taken and all results back, then let the pipeline empty
  task automatic settle();
    while (bytes_taken != bytes_queued || expected_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stage_byte(input logic [7:0] b);
    stage_q.insert(stage_q.size(), b);
  endtask

  task automatic flush_stage(input bit fin_last);
    feed_t f;
    foreach (stage_q[i]) begin
      f.data = stage_q[i];
      f.fin  = fin_last && (i == stage_q.size() - 1);
      feed_q.insert(feed_q.size(), f);
    end
    bytes_queued += stage_q.size();
    stage_q.delete();
  endtask

  task automatic push_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) stage_byte(s[i]);
    flush_stage(fin_last);
  endtask

  task automatic add_filler();
    repeat ($urandom_range(1, 3))
      stage_byte(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
  endtask

  task automatic add_gap();
    repeat ($urandom_range(0, 2))
      stage_byte(gap_chars[$urandom_range(0, gap_chars.len() - 1)]);
  endtask

  // string with escapes and structural characters that must not count
  task automatic add_string();
    logic [7:0] c;
    stage_byte(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          stage_byte(CH_BSLASH);
          stage_byte(8'($urandom_range(0, 255)));
        end
        2: stage_byte(CH_LBRACE);
        3: stage_byte(CH_RBRACE);
        4: stage_byte(CH_RBRACKET);
        default: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE || c == CH_BSLASH) c = filler_chars[0];
          stage_byte(c);
        end
      endcase
    end
    stage_byte(CH_QUOTE);
  endtask

  task automatic add_object(input int unsigned lvl);
    stage_byte(CH_LBRACE);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0, 1: add_string();
        2: begin
          if (lvl < 3) add_object(lvl + 1);
          else add_filler();
        end
        default: add_filler();
      endcase
    end
    stage_byte(CH_RBRACE);
  endtask

  task automatic build_buffer(input int unsigned size);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat (size) stage_byte(8'($urandom_range(0, 255)));
    end else if (mode < 13) begin
      add_gap();
      stage_byte(CH_RBRACKET);
      repeat ($urandom_range(0, 3)) stage_byte(8'($urandom_range(0, 255)));
    end else begin
      do begin
        add_gap();
        add_object(1);
      end while (stage_q.size() < size);
      if (mode < 25) begin
        // buffer ends inside an object
        stage_byte(CH_LBRACE);
        case ($urandom_range(0, 2))
          0: add_filler();
          1: begin
            stage_byte(CH_QUOTE);
            add_filler();
          end
          default: add_object(2);
        endcase
      end else if (mode >= 37) begin
        add_gap();
        stage_byte(CH_RBRACKET);
        while (stage_q.size() < size) stage_byte(8'($urandom_range(0, 255)));
      end
    end
    flush_stage(1'b1);
  endtask

  task automatic pick_config(output int unsigned buf_len);
    ofs_t start_val;
    ofs_t len_val;
    ofs_t cnt_val;
    int unsigned pick;
    buf_len = $urandom_range(6, 48);
    pick = $urandom_range(0, 9);
    if (pick == 0) start_val = '0;
    else if (pick == 1) start_val = ofs_t'('1) - ofs_t'($urandom_range(0, 20));
    else start_val = ofs_t'({$urandom(), $urandom()});
    pick = $urandom_range(0, 19);
    if (pick == 0) len_val = '0;
    else if (pick == 1) len_val = '1;
    else if (pick < 4) len_val = ofs_t'({$urandom(), $urandom()});
    else len_val = ofs_t'(buf_len + $urandom_range(0, 4));
    cnt_val = ofs_t'({$urandom(), $urandom()});
    pick = $urandom_range(0, 19);
    if (pick < 3) cnt_val[PC_BITS-1:0] = PC_BITS'(1);
    else if (pick < 5) cnt_val[PC_BITS-1:0] = PC_BITS'(MAX_PARTITIONS);
    else if (pick == 5) cnt_val[PC_BITS-1:0] = '0;
    else if (pick == 6) cnt_val[PC_BITS-1:0] = '1;
    else cnt_val[PC_BITS-1:0] = PC_BITS'($urandom_range(2, 16));
    write_reg(REG_ARRAY_START, start_val);
    write_reg(REG_PAYLOAD_LEN, len_val);
    write_reg(REG_PART_COUNT, cnt_val);
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, ofs_t'({$urandom(), $urandom()}));
  endtask

  initial begin
    int unsigned buf_len;
    int unsigned phase;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    base_ofs     = '0;
    pay_len      = '0;
    req_count    = PC_BITS'(1);
    restart_scan();
    bytes_queued = 0;
    bytes_taken  = 0;
    err_count    = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: one partition covering the payload whatever the bytes
    stage_byte(CH_LBRACE);
    stage_byte(8'hFF);
    stage_byte(8'h00);
    stage_byte(CH_RBRACE);
    flush_stage(1'b1);

    settle();
    write_reg(REG_ARRAY_START, ofs_t'(100));
    write_reg(REG_PAYLOAD_LEN, ofs_t'(12));
    write_reg(REG_PART_COUNT, ofs_t'(3));
    write_reg(REG_SPARE, '1);
    // escaped quote and brace inside a string, a cut, bytes ignored after the close
    push_text("{\"x\\\"}\"}{}]{", 1'b1);
    push_text("]", 1'b1);
    push_text("{", 1'b1);

    settle();
    write_reg(REG_PART_COUNT, ofs_t'(0));
    push_text("{}", 1'b1);

    // count saturates, cut and closing range on the same byte
    settle();
    write_reg(REG_PART_COUNT, '1);
    push_text("{}{}", 1'b1);

    phase = 0;
    while (bytes_queued < RANDOM_BYTES + 30) begin
      settle();
      calm = (phase % 4 == 3);
      pick_config(buf_len);
      repeat ($urandom_range(2, 5)) build_buffer(buf_len);
      // leave a buffer open across the next register writes now and then
      if ($urandom_range(0, 4) == 0) begin
        add_gap();
        add_object(1);
        flush_stage(1'b0);
      end
      phase++;
    end

    while (bytes_taken != bytes_queued || expected_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/jops_pkg.sv
design/jops_in_if.sv
design/jops_out_if.sv
design/jops_cfg_if.sv
design/jops_div.sv
design/jops_datapath.sv
design/jops_ctrl.sv
design/json_object_partition_splitter_top.sv
dv/json_object_partition_splitter_top_test.sv
